// ===== rtl/mm3_pkg.sv =====
package mm3_pkg;

  localparam logic [31:0] MIX_C1   = 32'hcc9e2d51;
  localparam logic [31:0] MIX_C2   = 32'h1b873593;
  localparam logic [31:0] MIX_N    = 32'he6546b64;
  localparam logic [31:0] FMIX_C1  = 32'h85ebca6b;
  localparam logic [31:0] FMIX_C2  = 32'hc2b2ae35;
  localparam int unsigned ROT_K    = 15;
  localparam int unsigned ROT_H    = 13;
  localparam logic [2:0]  FULL_CNT = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_K1,
    ST_K2,
    ST_MIX,
    ST_F1,
    ST_F2,
    ST_OUT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic k1;
    logic k2;
    logic mix;
    logic f1;
    logic f2;
    logic emit;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last;
  } dp_status_t;

  function automatic logic [31:0] rotl32(input logic [31:0] v, input int unsigned r);
    rotl32 = (v << r) | (v >> (32 - r));
  endfunction

endpackage

// ===== rtl/mm3_ctrl.sv =====
module mm3_ctrl
  import mm3_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  state_t state;
  state_t state_next;
  logic   out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = (state != ST_IDLE);
    // The output register drains independently of the state machine.
    out_valid_next = out_valid && out_stall;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_K1;
        end
      end
      ST_K1: begin
        cmd.k1     = 1'b1;
        state_next = ST_K2;
      end
      ST_K2: begin
        cmd.k2     = 1'b1;
        state_next = ST_MIX;
      end
      ST_MIX: begin
        cmd.mix    = 1'b1;
        state_next = status.last ? ST_F1 : ST_IDLE;
      end
      ST_F1: begin
        cmd.f1     = 1'b1;
        state_next = ST_F2;
      end
      ST_F2: begin
        cmd.f2     = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid || !out_stall) begin
          cmd.emit       = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/mm3_datapath.sv =====
module mm3_datapath
  import mm3_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic [31:0] seed,
  input  logic [31:0] data_word,
  input  logic [2:0]  byte_count,
  input  logic        last,
  input  dp_cmd_t     cmd,
  output dp_status_t  status,
  output logic [31:0] hash
);

  logic [31:0] seed_value;
  logic        busy;
  logic [31:0] word;
  logic [2:0]  count;
  logic        last_flag;
  logic [31:0] k;
  logic [31:0] acc;
  logic [31:0] len;

  logic [2:0]  count_sat;
  logic [31:0] word_mask;
  logic [31:0] acc_base;
  logic [31:0] h_xor;
  logic [31:0] h_rot;
  logic [31:0] h_mix;
  logic [31:0] len_next;

  assign status.last = last_flag;

  always_comb begin
    count_sat = (byte_count > FULL_CNT) ? FULL_CNT : byte_count;
    case (count_sat)
      3'd0:    word_mask = 32'h0000_0000;
      3'd1:    word_mask = 32'h0000_00ff;
      3'd2:    word_mask = 32'h0000_ffff;
      3'd3:    word_mask = 32'h00ff_ffff;
      default: word_mask = 32'hffff_ffff;
    endcase
  end

  // A full word gets the rotate and times-five step; a tail is only XORed in.
  always_comb begin
    h_xor    = acc ^ k;
    h_rot    = rotl32(h_xor, ROT_H);
    len_next = len + {29'd0, count};
    if (count == FULL_CNT) begin
      h_mix = (h_rot << 2) + h_rot + MIX_N;
    end else if (count != 3'd0) begin
      h_mix = h_xor;
    end else begin
      h_mix = acc;
    end
  end

  assign acc_base = busy ? acc : seed_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed_value <= '0;
      busy       <= 1'b0;
    end else begin
      if (cfg_valid) begin
        seed_value <= seed;
      end
      if (cmd.load) begin
        busy <= 1'b1;
      end else if (cmd.mix && last_flag) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      word      <= data_word & word_mask;
      count     <= count_sat;
      last_flag <= last;
      acc       <= acc_base;
      if (!busy) begin
        len <= '0;
      end
    end
    if (cmd.k1) begin
      k <= word * MIX_C1;
    end
    if (cmd.k2) begin
      k <= rotl32(k, ROT_K) * MIX_C2;
    end
    if (cmd.mix) begin
      len <= len_next;
      acc <= last_flag ? (h_mix ^ len_next) : h_mix;
    end
    if (cmd.f1) begin
      acc <= (acc ^ (acc >> 16)) * FMIX_C1;
    end
    if (cmd.f2) begin
      acc <= (acc ^ (acc >> 13)) * FMIX_C2;
    end
    if (cmd.emit) begin
      hash <= acc ^ (acc >> 16);
    end
  end

endmodule

// ===== rtl/murmur3_32_hash.sv =====
// Channel   Handshake              Word
// in        in_valid / in_stall    data_word, byte_count, last
// out       out_valid / out_stall  hash
// cfg       cfg_valid / cfg_ready  seed
//
// Each input word goes through the accept state, two multiply states of the k mix
// and one state that folds it into the running hash; in_stall holds off the next word.
// A last word then goes through the final avalanche: two multiply stages and
// the output state, which waits only while the output register is full and stalled.
// Reset clears the seed to zero and returns the controller to idle.
// The output register holds the hash while out_stall is high; new words are
// still taken in that time until a second hash is ready for the output register.
module murmur3_32_hash
  import mm3_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] data_word,
  input  logic [2:0]  byte_count,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] hash,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] seed
);

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  mm3_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  mm3_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .seed       (seed),
    .data_word  (data_word),
    .byte_count (byte_count),
    .last       (last),
    .cmd        (cmd),
    .status     (status),
    .hash       (hash)
  );

endmodule

// ===== tb/murmur3_32_hash_tb.sv =====
`timescale 1ns / 100ps

module murmur3_32_hash_tb;
  import mm3_pkg::*;

  localparam int QUIET_CYCLES = 16;
  localparam int MAX_GAP = 40;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] data_word;
  logic [2:0]  byte_count;
  logic        last;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] hash;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] seed;

  // Predictor state.
  logic [31:0] seed_shadow;
  logic [31:0] run_hash;
  logic [31:0] msg_bytes;
  logic        msg_open;
  logic [31:0] hash_expect_q[$];
  logic [31:0] want_hash;

  int idle_pct;
  int stall_pct;
  int hold_len;
  int fail_count;
  int words_sent;
  int msgs_sent;
  int hashes_checked;
  int seeds_written;

  murmur3_32_hash DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .data_word (data_word),
    .byte_count(byte_count),
    .last      (last),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .hash      (hash),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .seed      (seed)
  );

  always #5 clk = ~clk;

  function automatic logic [31:0] scramble_k(input logic [31:0] k);
    logic [31:0] t;
    t = k * MIX_C1;
    t = {t[16:0], t[31:17]};
    return t * MIX_C2;
  endfunction

  function automatic logic [31:0] avalanche_hash(input logic [31:0] h);
    logic [31:0] t;
    t = h ^ (h >> 16);
    t = t * FMIX_C1;
    t = t ^ (t >> 13);
    t = t * FMIX_C2;
    return t ^ (t >> 16);
  endfunction

  // Advances the running hash by one accepted word; queues a hash on a last word.
  task automatic absorb_word(input logic [31:0] w, input logic [2:0] cnt, input logic lst);
    logic [31:0] h;
    logic [31:0] mask;
    logic [2:0]  n;
    n = (cnt > FULL_CNT) ? FULL_CNT : cnt;
    if (!msg_open) begin
      run_hash = seed_shadow;
      msg_bytes = '0;
      msg_open = 1'b1;
    end
    h = run_hash;
    if (n == FULL_CNT) begin
      h = h ^ scramble_k(w);
      h = {h[18:0], h[31:19]};
      h = h * 32'd5 + MIX_N;
    end else if (n != 0) begin
      mask = (32'h1 << (8 * n)) - 32'h1;
      h = h ^ scramble_k(w & mask);
    end
    msg_bytes = msg_bytes + {29'd0, n};
    run_hash = h;
    if (lst) begin
      hash_expect_q.push_back(avalanche_hash(h ^ msg_bytes));
      run_hash = seed_shadow;
      msg_bytes = '0;
      msg_open = 1'b0;
      msgs_sent++;
    end
  endtask

  task automatic send_word(input logic [31:0] w, input logic [2:0] cnt, input logic lst);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < idle_pct) gap++;
    repeat (gap) begin
      @(negedge clk);
      in_valid = 1'b0;
      data_word = $urandom;
      byte_count = 3'($urandom_range(7));
      last = 1'($urandom_range(1));
    end
    @(negedge clk);
    in_valid = 1'b1;
    data_word = w;
    byte_count = cnt;
    last = lst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
    absorb_word(w, cnt, lst);
  endtask

  // Lowers the input valid, then waits for every queued hash and a quiet spell.
  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (hash_expect_q.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_seed(input logic [31:0] value);
    @(negedge clk);
    cfg_valid = 1'b1;
    seed = value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    seed_shadow = value;
    seeds_written++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // A well-formed message of the given length with random content.
  task automatic send_message(input int nbytes);
    int nfull;
    int tail;
    nfull = nbytes / 4;
    tail = nbytes % 4;
    if (tail == 0 && nfull > 0 && $urandom_range(1)) begin
      repeat (nfull - 1) send_word($urandom, FULL_CNT, 1'b0);
      send_word($urandom, FULL_CNT, 1'b1);
    end else begin
      repeat (nfull) send_word($urandom, FULL_CNT, 1'b0);
      send_word($urandom, tail[2:0], 1'b1);
    end
  endtask

  task automatic test_directed_cases();
    idle_pct = 0;
    stall_pct = 0;
    write_seed(32'h0);
    // Empty message, every tail length with junk in the unused bytes, all-zero word.
    send_word(32'h0, 3'd0, 1'b1);
    send_word(32'hffffffff, 3'd1, 1'b1);
    send_word(32'hffffffff, 3'd2, 1'b1);
    send_word(32'hffffffff, 3'd3, 1'b1);
    send_word(32'hffffffff, 3'd4, 1'b1);
    send_word(32'h0, 3'd4, 1'b1);
    // Counts above four behave as four.
    send_word($urandom, 3'd5, 1'b1);
    send_word($urandom, 3'd6, 1'b1);
    send_word($urandom, 3'd7, 1'b1);
    // A partial word in the middle of a message.
    send_word($urandom, 3'd2, 1'b0);
    send_word($urandom, 3'd4, 1'b0);
    send_word($urandom, 3'd3, 1'b1);
    // Zero-count words in the middle of a message.
    send_word($urandom, 3'd0, 1'b0);
    send_word($urandom, 3'd4, 1'b0);
    send_word($urandom, 3'd0, 1'b0);
    send_word($urandom, 3'd0, 1'b1);
    wait_drained();
  endtask

  task automatic test_seed_timing();
    write_seed(32'hffffffff);
    send_word(32'h0, 3'd0, 1'b1);
    send_word($urandom, 3'd4, 1'b0);
    wait_drained();
    // The open message keeps the seed it started with.
    write_seed(32'h12345678);
    send_word($urandom, 3'd1, 1'b1);
    send_word($urandom, 3'd4, 1'b1);
    wait_drained();
  endtask

  task automatic test_random_traffic(input int n_words, input int idle, input int stall,
                                     input logic [31:0] seed_value, input bit pause_midway);
    int start;
    int len;
    write_seed(seed_value);
    idle_pct = idle;
    stall_pct = stall;
    start = words_sent;
    while (words_sent - start < n_words) begin
      if ($urandom_range(99) < 80) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(25, 96) : $urandom_range(0, 24);
        send_message(len);
      end else begin
        // Loose words: any count, last at random.
        send_word($urandom, 3'($urandom_range(7)), ($urandom_range(3) == 0));
      end
      if (pause_midway && words_sent - start >= n_words / 2) begin
        pause_midway = 0;
        wait_drained();
      end
    end
    send_word($urandom, 3'($urandom_range(4)), 1'b1);
    wait_drained();
  endtask

  // The receiver holds off long enough for the block to back up into its input.
  task automatic test_backpressure();
    write_seed($urandom);
    idle_pct = 0;
    stall_pct = 0;
    @(posedge clk);
    hold_len = 300;
    repeat (40) send_message($urandom_range(0, 6));
    wait_drained();
  endtask

  always @(negedge clk) begin
    if (rst) begin
      out_stall = 1'b0;
    end else if (hold_len > 0) begin
      out_stall = 1'b1;
      hold_len--;
    end else begin
      out_stall = ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (hash_expect_q.size() == 0) begin
        $error("hash word 0x%08h arrived with no message pending", hash);
        fail_count++;
      end else begin
        want_hash = hash_expect_q.pop_front();
        hashes_checked++;
        if (hash !== want_hash) begin
          $error("hash mismatch: expected 0x%08h, actual 0x%08h", want_hash, hash);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("murmur3_32_hash verification failed");
    $finish;
  end

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    data_word = '0;
    byte_count = '0;
    last = 1'b0;
    cfg_valid = 1'b0;
    seed = '0;
    seed_shadow = '0;
    run_hash = '0;
    msg_bytes = '0;
    msg_open = 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    hold_len = 0;
    fail_count = 0;
    words_sent = 0;
    msgs_sent = 0;
    hashes_checked = 0;
    seeds_written = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed_cases();
    test_seed_timing();
    test_random_traffic(270, 0, 0, 32'h0, 0);
    test_random_traffic(270, 87, 0, $urandom, 1);
    test_random_traffic(270, 0, 87, 32'hffffffff, 0);
    test_random_traffic(270, 29, 29, 32'h80000000, 0);
    test_backpressure();

    $display("Sent %0d words in %0d messages under %0d seed writes; %0d hashes checked.",
             words_sent, msgs_sent, seeds_written, hashes_checked);
    $display("Traffic ran at full rate, with sender gaps, receiver stalls and a long hold-off.");
    if (fail_count == 0) begin
      $display("murmur3_32_hash verification clean");
    end else begin
      $display("murmur3_32_hash verification failed");
    end
    $finish;
  end

endmodule
